>>> src/gfau_pkg.sv
// ----------------------------------------------------------------------------
// gfau_pkg
// Shared types, constants and helpers of the GF(2^m) arithmetic unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned MaxDegree = 32;
  localparam int unsigned DegW      = $clog2(DataW + 1);
  localparam int unsigned IdxW      = $clog2(DataW);
  localparam int unsigned Digit     = 8;   // multiplier bits per cycle
  localparam int unsigned ModeW     = 2;
  localparam int unsigned ActionW   = 3;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [DataW-1:0] PolyReset = DataW'(29);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIELD_MODE     = 1'b0,
    CFG_REDUCTION_POLY = 1'b1
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_GF8  = 2'd0,
    MODE_GF16 = 2'd1,
    MODE_GF32 = 2'd2
  } field_mode_e;

  typedef enum logic [ActionW-1:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_INV = 3'd3,
    ACT_DIV = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_PRD,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [DataW-1:0]   operand_a;
    logic [DataW-1:0]   operand_b;
  } gfau_in_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             zero_divide;
  } gfau_out_t;

  // Active field: degree, element mask and reduction polynomial below x^m.
  typedef struct packed {
    logic [DegW-1:0]  deg;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] poly;
  } gfau_field_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gfau_mul_stat_t;

  function automatic logic [DegW-1:0] field_degree(logic [ModeW-1:0] mode);
    logic [DegW-1:0] d;
    unique case (field_mode_e'(mode))
      MODE_GF8:  d = DegW'(8);
      MODE_GF16: d = DegW'(16);
      default:   d = DegW'(32);  // mode three runs as GF(2^32)
    endcase
    if (d > DegW'(MaxDegree)) begin
      d = DegW'(MaxDegree);
    end
    return d;
  endfunction

  function automatic logic [DataW-1:0] degree_mask(logic [DegW-1:0] deg);
    logic [DataW-1:0] m;
    if (deg >= DegW'(DataW)) begin
      m = '1;
    end else begin
      m = (DataW'(1) << deg) - DataW'(1);
    end
    return m;
  endfunction

endpackage

>>> src/gf2m_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gf2m_arithmetic_unit
// Add, subtract, multiply, inverse and divide over GF(2^8/16/32) with a
// programmable reduction polynomial; one shared digit-serial multiplier.
//
//   channel  | signals                        | transfer when
//   ---------+--------------------------------+--------------------------
//   in       | in_valid_i, in_stall_o, in_data_i   | valid & !stall
//   out      | out_valid_o, out_stall_i, out_data_o| valid & !stall
//   cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i    | cfg_we_i
//
// One multiply on the shared unit is a launch, the digit steps and a
// hand-back. Add/subtract, a zero operand to invert and a zero divisor skip the
// multiplier; multiply uses one multiply, inverse 2m - 2 multiplies and
// divide one more than inverse.
// in_stall_o is high while an item is in work; a result waiting in the
// output register does not block the next transfer in.
// Reset is asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module gf2m_arithmetic_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gfau_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [gfau_pkg::DataW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  gfau_pkg::gfau_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output gfau_pkg::gfau_out_t                 out_data_o
);

  localparam int unsigned DataW = gfau_pkg::DataW;
  localparam int unsigned DegW  = gfau_pkg::DegW;

  gfau_pkg::gfau_field_t    field;
  gfau_pkg::gfau_mul_stat_t mul_stat;
  logic [DataW-1:0]         mul_a, mul_b, mul_p;
  logic                     mul_start;

  gfau_pkg::state_e  state_q, state_d;
  gfau_pkg::action_e op_q, op_d;
  logic [DataW-1:0]  opa_q, opa_d;
  logic [DataW-1:0]  base_q, base_d;
  logic [DataW-1:0]  res_q, res_d;
  logic [DegW-1:0]   iter_q, iter_d;
  logic              err_q, err_d;
  logic              launched_q, launched_d;
  logic              in_xfer, out_load, out_valid_q, out_valid_d;
  logic [DataW-1:0]  a_m, b_m;
  gfau_pkg::gfau_out_t out_q;

  gfau_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .field_o     (field)
  );

  gfau_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .field_i   (field),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .stat_o    (mul_stat),
    .product_o (mul_p)
  );

  assign in_stall_o = (state_q != gfau_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign a_m        = in_data_i.operand_a & field.mask;
  assign b_m        = in_data_i.operand_b & field.mask;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    opa_d      = opa_q;
    base_d     = base_q;
    res_d      = res_q;
    iter_d     = iter_q;
    err_d      = err_q;
    launched_d = launched_q;
    mul_start  = 1'b0;
    mul_a      = base_q;
    mul_b      = base_q;
    out_load   = 1'b0;

    unique case (state_q)
      gfau_pkg::ST_IDLE: begin
        if (in_xfer) begin
          op_d       = gfau_pkg::action_e'(in_data_i.action);
          err_d      = 1'b0;
          launched_d = 1'b0;
          iter_d     = '0;
          unique case (gfau_pkg::action_e'(in_data_i.action))
            gfau_pkg::ACT_ADD, gfau_pkg::ACT_SUB: begin
              res_d   = a_m ^ b_m;
              state_d = gfau_pkg::ST_DONE;
            end
            gfau_pkg::ACT_MUL: begin
              opa_d   = a_m;
              res_d   = b_m;
              state_d = gfau_pkg::ST_FIN;
            end
            gfau_pkg::ACT_INV: begin
              if (a_m == '0) begin
                res_d   = '0;
                err_d   = 1'b1;
                state_d = gfau_pkg::ST_DONE;
              end else begin
                base_d  = a_m;
                res_d   = DataW'(1);
                state_d = gfau_pkg::ST_SQR;
              end
            end
            gfau_pkg::ACT_DIV: begin
              if (b_m == '0) begin
                res_d   = '0;
                err_d   = 1'b1;
                state_d = gfau_pkg::ST_DONE;
              end else begin
                opa_d   = a_m;
                base_d  = b_m;
                res_d   = DataW'(1);
                state_d = gfau_pkg::ST_SQR;
              end
            end
            default: begin
              res_d   = '0;
              state_d = gfau_pkg::ST_DONE;
            end
          endcase
        end
      end

      // base = base^2, one per exponent bit
      gfau_pkg::ST_SQR: begin
        mul_a = base_q;
        mul_b = base_q;
        if (!launched_q) begin
          mul_start  = 1'b1;
          launched_d = 1'b1;
        end else if (mul_stat.done) begin
          base_d     = mul_p;
          iter_d     = iter_q + DegW'(1);
          launched_d = 1'b0;
          state_d    = gfau_pkg::ST_PRD;
        end
      end

      // exponent 2^m - 2 has every bit set but bit 0
      gfau_pkg::ST_PRD: begin
        mul_a = res_q;
        mul_b = base_q;
        if (!launched_q) begin
          mul_start  = 1'b1;
          launched_d = 1'b1;
        end else if (mul_stat.done) begin
          res_d      = mul_p;
          launched_d = 1'b0;
          if (iter_q == field.deg - DegW'(1)) begin
            state_d = (op_q == gfau_pkg::ACT_DIV) ? gfau_pkg::ST_FIN
                                                  : gfau_pkg::ST_DONE;
          end else begin
            state_d = gfau_pkg::ST_SQR;
          end
        end
      end

      gfau_pkg::ST_FIN: begin
        mul_a = opa_q;
        mul_b = res_q;
        if (!launched_q) begin
          mul_start  = 1'b1;
          launched_d = 1'b1;
        end else if (mul_stat.done) begin
          res_d      = mul_p;
          launched_d = 1'b0;
          state_d    = gfau_pkg::ST_DONE;
        end
      end

      gfau_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = gfau_pkg::ST_IDLE;
        end
      end

      default: state_d = gfau_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfau_pkg::ST_IDLE;
      launched_q  <= 1'b0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    opa_q  <= opa_d;
    base_q <= base_d;
    res_q  <= res_d;
    err_q  <= err_d;
    if (out_load) begin
      out_q.result      <= res_q;
      out_q.zero_divide <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_start_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> (state_q == gfau_pkg::ST_SQR || state_q == gfau_pkg::ST_PRD ||
                   state_q == gfau_pkg::ST_FIN))
    else $error("multiplier launched outside a compute state");

  a_start_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier launched while busy");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != gfau_pkg::ST_IDLE)
    else $error("accepted item did not start work");

  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gfau_pkg::ST_PRD |-> iter_q < field.deg)
    else $error("exponent bit counter past field degree");

  a_err_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_divide) |-> out_data_o.result == '0)
    else $error("zero_divide with nonzero result");
`endif

endmodule

>>> src/gfau_cfg.sv
// ----------------------------------------------------------------------------
// gfau_cfg
// Configuration registers and the derived field description.
// ----------------------------------------------------------------------------
module gfau_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gfau_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [gfau_pkg::DataW-1:0]           cfg_wdata_i,
  output gfau_pkg::gfau_field_t                field_o
);

  logic [gfau_pkg::ModeW-1:0] mode_q;
  logic [gfau_pkg::DataW-1:0] poly_q;
  logic [gfau_pkg::DegW-1:0]  deg;
  logic [gfau_pkg::DataW-1:0] mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= gfau_pkg::MODE_GF8;
      poly_q <= gfau_pkg::PolyReset;
    end else if (cfg_we_i) begin
      unique case (gfau_pkg::cfg_idx_e'(cfg_idx_i))
        gfau_pkg::CFG_FIELD_MODE:     mode_q <= cfg_wdata_i[gfau_pkg::ModeW-1:0];
        gfau_pkg::CFG_REDUCTION_POLY: poly_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign deg  = gfau_pkg::field_degree(mode_q);
  assign mask = gfau_pkg::degree_mask(deg);

  assign field_o.deg  = deg;
  assign field_o.mask = mask;
  assign field_o.poly = poly_q & mask;

endmodule

>>> src/gfau_mul.sv
// ----------------------------------------------------------------------------
// gfau_mul
// Digit-serial GF(2^m) multiplier, MSB-first interleaved reduction,
// Digit bits of the second operand per cycle.
// ----------------------------------------------------------------------------
module gfau_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gfau_pkg::gfau_field_t         field_i,
  input  logic                          start_i,
  input  logic [gfau_pkg::DataW-1:0]    a_i,
  input  logic [gfau_pkg::DataW-1:0]    b_i,
  output gfau_pkg::gfau_mul_stat_t      stat_o,
  output logic [gfau_pkg::DataW-1:0]    product_o
);

  localparam int unsigned DataW = gfau_pkg::DataW;
  localparam int unsigned DegW  = gfau_pkg::DegW;
  localparam int unsigned Digit = gfau_pkg::Digit;

  logic [DataW-1:0]          r_q, r_d;
  logic [DataW-1:0]          a_q;
  logic [DataW-1:0]          b_q, b_d;   // remaining bits, next one at the MSB
  logic [DegW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, done_q;
  logic [gfau_pkg::IdxW-1:0] top_idx;

  assign top_idx = gfau_pkg::IdxW'(field_i.deg - DegW'(1));

  always_comb begin
    r_d = r_q;
    b_d = b_q;
    for (int j = 0; j < Digit; j++) begin
      if (cnt_q > DegW'(j)) begin
        r_d = ((r_d << 1) & field_i.mask)
            ^ (r_d[top_idx] ? field_i.poly : '0)
            ^ (b_d[DataW-1] ? a_q : '0);
        b_d = b_d << 1;
      end
    end
    cnt_d = (cnt_q > DegW'(Digit)) ? cnt_q - DegW'(Digit) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= field_i.deg;
    end else if (busy_q) begin
      cnt_q <= cnt_d;
      if (cnt_d == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      a_q <= a_i;
      b_q <= b_i << (DegW'(DataW) - field_i.deg);
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= b_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign product_o   = r_q;

endmodule
